// ----- sv/fdes_pkg.sv -----
package fdes_pkg;

  localparam logic [1:0] ACT_START  = 2'd0;
  localparam logic [1:0] ACT_EXEC   = 2'd1;
  localparam logic [1:0] ACT_CANCEL = 2'd2;

  localparam logic [1:0] FND_OK     = 2'd0;
  localparam logic [1:0] FND_P2_BAD = 2'd1;

  localparam logic [2:0] RES_OK       = 3'd0;
  localparam logic [2:0] RES_FAILED   = 3'd1;
  localparam logic [2:0] RES_PENDING  = 3'd2;
  localparam logic [2:0] RES_CANCELED = 3'd3;
  localparam logic [2:0] RES_INVALID  = 3'd5;

  localparam logic [1:0] CMD_NONE  = 2'd0;
  localparam logic [1:0] CMD_P1    = 2'd1;
  localparam logic [1:0] CMD_ERASE = 2'd2;
  localparam logic [1:0] CMD_P2    = 2'd3;

  localparam logic [1:0] PH_IDLE       = 2'd0;
  localparam logic [1:0] PH_WAIT_P1    = 2'd1;
  localparam logic [1:0] PH_WAIT_ERASE = 2'd2;
  localparam logic [1:0] PH_WAIT_P2    = 2'd3;

  typedef struct packed {
    logic [1:0] action;
    logic [1:0] finder_result;
    logic [7:0] last_sector;
    logic       task_accepted;
    logic       command_accepted;
    logic [2:0] flash_result;
  } in_beat_t;

  typedef struct packed {
    logic       start_ok;
    logic [1:0] command;
    logic [7:0] sector;
    logic       busy_res;
    logic [2:0] job_result;
    logic       task_release;
  } out_beat_t;

  typedef struct packed {
    logic [1:0] phase;
    logic       busy;
    logic [2:0] result_code;
    logic [1:0] finder;
  } ctl_state_t;

endpackage

// ----- sv/flash_dataset_erase_sequencer_core.sv -----
// channel | ports                          | beat
// input   | in_valid, in_stall, in_data    | in_beat_t: event and its arguments
// result  | out_valid, out_stall, out_data | out_beat_t: command and job status
//
// One event per cycle sustained while out_stall is low; an accepted beat goes through
// the input register, then the result register, and from there onto the result channel.
// The job state advances as a beat moves from the input register to the result register.
// Synchronous active-low reset: phase idle, not busy, result ok, both stages empty.
// out_stall holds both stages; in_stall rises only when the input register cannot move.
module flash_dataset_erase_sequencer_core import fdes_pkg::*; #(
  parameter int MAX_SECTORS = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_data
);

  localparam int MAX_IDX = (MAX_SECTORS > 256) ? 255 : MAX_SECTORS - 1;
  localparam int IW      = (MAX_SECTORS >= 256) ? 8 :
                           ((MAX_SECTORS > 1) ? $clog2(MAX_SECTORS) : 1);

  logic          in_vld_r;
  in_beat_t      in_beat_r;
  logic          out_vld_r;
  out_beat_t     out_beat_r;
  ctl_state_t    st_r, st_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  out_beat_t     res;
  logic          adv_out;
  logic          adv_in;

  assign adv_out   = !out_vld_r || !out_stall;
  assign adv_in    = !in_vld_r || adv_out;
  assign in_stall  = !adv_in;
  assign out_valid = out_vld_r;
  assign out_data  = out_beat_r;

  fdes_step #(
    .MAX_IDX (MAX_IDX),
    .IW      (IW)
  ) u_step (
    .beat    (in_beat_r),
    .cur     (st_r),
    .cur_idx (idx_r),
    .nxt     (st_nxt),
    .nxt_idx (idx_nxt),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      st_r      <= '{phase: PH_IDLE, busy: 1'b0, result_code: RES_OK, finder: FND_OK};
      idx_r     <= '0;
    end else begin
      if (adv_in) begin
        in_vld_r <= in_valid;
      end
      if (adv_out) begin
        out_vld_r <= in_vld_r;
        if (in_vld_r) begin
          st_r  <= st_nxt;
          idx_r <= idx_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_in && in_valid) begin
      in_beat_r <= in_data;
    end
    if (adv_out && in_vld_r) begin
      out_beat_r <= res;
    end
  end

endmodule

// ----- sv/fdes_step.sv -----
module fdes_step import fdes_pkg::*; #(
  parameter int MAX_IDX = 255,
  parameter int IW      = 8
) (
  input  in_beat_t   beat,
  input  ctl_state_t cur,
  input  logic [IW-1:0] cur_idx,
  output ctl_state_t nxt,
  output logic [IW-1:0] nxt_idx,
  output out_beat_t  res
);

  logic [2:0]    fres;
  logic [7:0]    last_sat;
  logic [IW-1:0] idx_dec;

  assign fres     = (beat.flash_result > RES_INVALID) ? RES_INVALID : beat.flash_result;
  assign last_sat = (beat.last_sector > 8'(MAX_IDX)) ? 8'(MAX_IDX) : beat.last_sector;
  assign idx_dec  = cur_idx - IW'(1);

  always_comb begin
    nxt              = cur;
    nxt_idx          = cur_idx;
    res.start_ok     = 1'b0;
    res.command      = CMD_NONE;
    res.sector       = 8'd0;
    res.task_release = 1'b0;
    case (beat.action)
      ACT_START: begin
        if (cur.phase == PH_IDLE && beat.task_accepted) begin
          res.start_ok    = 1'b1;
          nxt.busy        = 1'b1;
          nxt.result_code = RES_PENDING;
          nxt.finder      = beat.finder_result;
          nxt_idx         = IW'(last_sat);
        end
      end
      ACT_EXEC: begin
        if (cur.busy) begin
          case (cur.phase)
            PH_IDLE: begin
              if (cur.finder == FND_OK || cur.finder == FND_P2_BAD) begin
                res.command = CMD_P1;
                nxt.phase   = PH_WAIT_P1;
              end else begin
                res.command = CMD_ERASE;
                res.sector  = 8'(cur_idx);
                nxt.phase   = PH_WAIT_ERASE;
              end
            end
            PH_WAIT_P1: begin
              if (fres == RES_OK) begin
                res.command = CMD_ERASE;
                res.sector  = 8'(cur_idx);
                nxt.phase   = PH_WAIT_ERASE;
              end
            end
            PH_WAIT_ERASE: begin
              if (fres == RES_OK) begin
                if (cur_idx != '0) begin
                  nxt_idx     = idx_dec;
                  res.command = CMD_ERASE;
                  res.sector  = 8'(idx_dec);
                  nxt.phase   = PH_WAIT_ERASE;
                end else begin
                  res.command = CMD_P2;
                  nxt.phase   = PH_WAIT_P2;
                end
              end
            end
            default: begin
            end
          endcase
          if (res.command == CMD_NONE) begin
            nxt.result_code  = fres;
            nxt.busy         = 1'b0;
            nxt.phase        = PH_IDLE;
            res.task_release = 1'b1;
          end else if (!beat.command_accepted) begin
            nxt.result_code  = RES_FAILED;
            nxt.busy         = 1'b0;
            nxt.phase        = PH_IDLE;
            res.task_release = 1'b1;
          end
        end
      end
      ACT_CANCEL: begin
        nxt.result_code  = RES_CANCELED;
        nxt.busy         = 1'b0;
        nxt.phase        = PH_IDLE;
        res.task_release = 1'b1;
      end
      default: begin
      end
    endcase
    res.busy_res   = nxt.busy;
    res.job_result = nxt.result_code;
  end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
  import fdes_pkg::*;

  localparam int MAX_SECTORS = 256;
  localparam int ITEM_TARGET = 1950;

  typedef struct {
    in_beat_t beat;
    bit       drain;
  } stim_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_data;

  stim_t     stim_q[$];
  out_beat_t status_q[$];
  int        n_in, n_out, n_err, n_started, n_closed, n_items;
  int        in_gap, out_gap, in_quiet, out_quiet;
  bit        drain_next;

  logic [1:0] job_phase = PH_IDLE;
  logic       job_busy = 1'b0;
  logic [2:0] job_res = RES_OK;
  logic [1:0] job_finder = FND_OK;
  logic [8:0] job_sector = '0;

  flash_dataset_erase_sequencer_core dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always #5 clk = ~clk;

  function automatic out_beat_t sequencer_step(in_beat_t b);
    out_beat_t  o;
    logic [2:0] fres;
    logic [2:0] code;
    logic       close;
    o = '0;
    close = 1'b0;
    code = RES_OK;
    fres = (b.flash_result > RES_INVALID) ? RES_INVALID : b.flash_result;
    case (b.action)
      ACT_START: begin
        if (job_phase == PH_IDLE && b.task_accepted) begin
          o.start_ok = 1'b1;
          job_busy = 1'b1;
          job_res = RES_PENDING;
          job_finder = b.finder_result;
          job_sector = (b.last_sector > MAX_SECTORS - 1) ? 9'(MAX_SECTORS - 1)
                                                         : {1'b0, b.last_sector};
          n_started++;
        end
      end
      ACT_EXEC: begin
        if (job_busy) begin
          case (job_phase)
            PH_IDLE: begin
              o.command = (job_finder == FND_OK || job_finder == FND_P2_BAD) ? CMD_P1
                                                                            : CMD_ERASE;
            end
            PH_WAIT_P1: begin
              o.command = (fres == RES_OK) ? CMD_ERASE : CMD_NONE;
            end
            PH_WAIT_ERASE: begin
              if (fres != RES_OK) begin
                o.command = CMD_NONE;
              end else if (job_sector != 0) begin
                job_sector = job_sector - 9'd1;
                o.command = CMD_ERASE;
              end else begin
                o.command = CMD_P2;
              end
            end
            default: o.command = CMD_NONE;
          endcase
          if (o.command == CMD_ERASE) o.sector = job_sector[7:0];
          if (o.command == CMD_NONE) begin
            close = 1'b1;
            code = fres;
          end else if (!b.command_accepted) begin
            close = 1'b1;
            code = RES_FAILED;
          end else begin
            case (o.command)
              CMD_P1:    job_phase = PH_WAIT_P1;
              CMD_ERASE: job_phase = PH_WAIT_ERASE;
              default:   job_phase = PH_WAIT_P2;
            endcase
          end
        end
      end
      ACT_CANCEL: begin
        close = 1'b1;
        code = RES_CANCELED;
      end
      default: ;
    endcase
    if (close) begin
      job_res = code;
      job_busy = 1'b0;
      job_phase = PH_IDLE;
      o.task_release = 1'b1;
      n_closed++;
    end
    o.busy_res = job_busy;
    o.job_result = job_res;
    return o;
  endfunction

  function automatic int gap_len(inout int quiet);
    int r;
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      quiet = $urandom_range(20, 80);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  function automatic in_beat_t rnd_beat();
    logic [31:0] r;
    r = $urandom;
    return r[$bits(in_beat_t)-1:0];
  endfunction

  function automatic in_beat_t mk(logic [1:0] act, logic [1:0] fnd, logic [7:0] last,
                                  logic task_ok, logic cmd_ok, logic [2:0] fres);
    in_beat_t b;
    b.action = act;
    b.finder_result = fnd;
    b.last_sector = last;
    b.task_accepted = task_ok;
    b.command_accepted = cmd_ok;
    b.flash_result = fres;
    return b;
  endfunction

  function automatic void push(in_beat_t b);
    stim_t s;
    s.beat = b;
    s.drain = drain_next;
    drain_next = 1'b0;
    stim_q.push_back(s);
    n_items++;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_err++;
    end
  endfunction

  always @(posedge clk) begin
    stim_t nxt;
    logic  vld;
    vld = in_valid;
    if (!rst_n) begin
      vld = 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        status_q.push_back(sequencer_step(in_data));
        n_in++;
        vld = 1'b0;
      end
      if (!vld) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (stim_q.size() > 0 && !(stim_q[0].drain && status_q.size() > 0)) begin
          nxt = stim_q.pop_front();
          in_data <= nxt.beat;
          vld = 1'b1;
          in_gap = gap_len(in_quiet);
        end
      end
    end
    in_valid <= vld;
  end

  always @(posedge clk) begin
    out_beat_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        n_out++;
        if (status_q.size() == 0) begin
          $error("result beat with nothing expected: %p", out_data);
          n_err++;
        end else begin
          want = status_q.pop_front();
          check_field("start_ok", want.start_ok, out_data.start_ok);
          check_field("command", want.command, out_data.command);
          check_field("sector", want.sector, out_data.sector);
          check_field("busy_res", want.busy_res, out_data.busy_res);
          check_field("job_result", want.job_result, out_data.job_result);
          check_field("task_release", want.task_release, out_data.task_release);
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        out_gap = gap_len(out_quiet);
      end
    end
  end

  initial begin
    #(5_000_000);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    in_beat_t b;
    logic [1:0] fnd;
    logic [7:0] last;
    int sel, len, next_drain;

    push(mk(ACT_EXEC, 2'd3, 8'hFF, 1'b1, 1'b1, 3'd7));
    push(mk(ACT_CANCEL, 2'd0, 8'h00, 1'b0, 1'b0, 3'd0));
    push(mk(2'd3, 2'd3, 8'hAA, 1'b1, 1'b1, 3'd4));
    push(mk(ACT_START, FND_OK, 8'h01, 1'b0, 1'b1, RES_OK));
    push(mk(ACT_START, FND_OK, 8'h01, 1'b1, 1'b0, RES_OK));
    push(mk(ACT_START, 2'd3, 8'hFF, 1'b1, 1'b0, RES_OK));
    push(mk(ACT_EXEC, 2'd0, 8'h00, 1'b0, 1'b1, RES_OK));
    push(mk(ACT_START, FND_OK, 8'h05, 1'b1, 1'b1, RES_OK));
    push(mk(ACT_EXEC, 2'd0, 8'h00, 1'b0, 1'b1, RES_OK));
    push(mk(ACT_EXEC, 2'd0, 8'h00, 1'b0, 1'b0, RES_OK));
    push(mk(ACT_START, FND_P2_BAD, 8'h00, 1'b1, 1'b0, RES_OK));
    push(mk(ACT_EXEC, 2'd0, 8'h00, 1'b0, 1'b1, RES_OK));
    push(mk(ACT_EXEC, 2'd0, 8'h00, 1'b0, 1'b1, RES_OK));
    push(mk(ACT_EXEC, 2'd0, 8'h00, 1'b0, 1'b1, RES_OK));
    push(mk(ACT_EXEC, 2'd0, 8'h00, 1'b0, 1'b1, RES_OK));
    push(mk(ACT_START, FND_OK, 8'h00, 1'b1, 1'b0, RES_OK));
    push(mk(ACT_EXEC, 2'd0, 8'h00, 1'b0, 1'b0, RES_OK));
    push(mk(ACT_START, FND_OK, 8'h00, 1'b1, 1'b0, RES_OK));
    push(mk(ACT_EXEC, 2'd0, 8'h00, 1'b0, 1'b1, RES_OK));
    push(mk(ACT_EXEC, 2'd0, 8'h00, 1'b0, 1'b1, RES_PENDING));
    push(mk(ACT_START, 2'd2, 8'h00, 1'b1, 1'b0, RES_OK));
    push(mk(ACT_EXEC, 2'd0, 8'h00, 1'b0, 1'b1, RES_OK));
    push(mk(ACT_EXEC, 2'd0, 8'h00, 1'b0, 1'b1, 3'd6));
    push(mk(ACT_START, 2'd2, 8'h01, 1'b1, 1'b0, RES_OK));
    push(mk(ACT_EXEC, 2'd0, 8'h00, 1'b0, 1'b1, RES_OK));
    push(mk(ACT_CANCEL, 2'd1, 8'h80, 1'b1, 1'b1, 3'd7));

    drain_next = 1'b1;
    next_drain = 500;
    while (n_items < ITEM_TARGET) begin
      if (n_items >= next_drain) begin
        drain_next = 1'b1;
        next_drain += 500;
      end
      sel = $urandom_range(0, 99);
      if (sel < 12) begin
        b = rnd_beat();
        push(b);
      end else begin
        fnd = 2'($urandom_range(0, 3));
        sel = $urandom_range(0, 99);
        if (sel < 2) last = 8'($urandom_range(128, 255));
        else if (sel < 12) last = 8'($urandom_range(8, 40));
        else last = 8'($urandom_range(0, 7));
        b = rnd_beat();
        b.action = ACT_START;
        b.finder_result = fnd;
        b.last_sector = last;
        b.task_accepted = ($urandom_range(0, 9) != 0);
        push(b);
        len = ((fnd == FND_OK || fnd == FND_P2_BAD) ? 1 : 0) + int'(last) + 3;
        for (int i = 0; i < len; i++) begin
          b = rnd_beat();
          sel = $urandom_range(0, 99);
          if (sel < 2) begin
            b.action = ACT_CANCEL;
            push(b);
            break;
          end
          b.action = (sel < 4) ? ACT_START : ACT_EXEC;
          b.command_accepted = ($urandom_range(0, 19) != 0);
          b.flash_result = ($urandom_range(0, 14) == 0) ? 3'($urandom_range(0, 7)) : RES_OK;
          push(b);
        end
      end
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    while (stim_q.size() != 0 || in_valid) @(posedge clk);
    while (status_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d event beats and checked %0d result beats.", n_in, n_out);
    $display("Jobs taken: %0d, jobs closed (finish, fail or cancel): %0d.",
             n_started, n_closed);
    if (n_err == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
